@@ rtl/sgsc_pkg.sv @@
`default_nettype none
package sgsc_pkg;

  // Table size and fixed values
  localparam int MaxServosDefault = 16;
  localparam logic signed [31:0] HOME_POSITION = 32'sd2048;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [15:0] HB_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] GOAL_STEP_RST  = 16'd512;
  localparam logic [14:0] MAX_VEL_RST    = 15'd200;
  localparam logic [4:0]  SCAN_CNT_RST   = 5'd12;

  // Register indexes
  localparam logic [1:0] REG_HB_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_GOAL_STEP  = 2'd1;
  localparam logic [1:0] REG_MAX_VEL    = 2'd2;
  localparam logic [1:0] REG_SCAN_CNT   = 2'd3;

  // Operation codes
  localparam logic [3:0] OP_TICK       = 4'd0;
  localparam logic [3:0] OP_HEARTBEAT  = 4'd1;
  localparam logic [3:0] OP_SAFETY     = 4'd2;
  localparam logic [3:0] OP_STOP       = 4'd3;
  localparam logic [3:0] OP_DISABLE    = 4'd4;
  localparam logic [3:0] OP_SCAN       = 4'd5;
  localparam logic [3:0] OP_ENABLE_ALL = 4'd6;
  localparam logic [3:0] OP_ENABLE_ONE = 4'd7;
  localparam logic [3:0] OP_GOAL       = 4'd8;
  localparam logic [3:0] OP_VELOCITY   = 4'd9;
  localparam logic [3:0] OP_CLEAR      = 4'd10;

  // Event codes
  localparam logic [1:0] EV_DONE    = 2'd0;
  localparam logic [1:0] EV_REJECT  = 2'd1;
  localparam logic [1:0] EV_REFUSED = 2'd2;
  localparam logic [1:0] EV_FAULT   = 2'd3;

  // Fault causes
  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_SAFETY = 2'd1;
  localparam logic [1:0] CAUSE_HB     = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec;
    logic search;
    logic apply;
    logic goal;
  } sgsc_cmd_t;

  typedef struct packed {
    logic search_done;
    logic apply_en;
  } sgsc_status_t;

endpackage
`default_nettype wire

@@ rtl/sgsc_ctrl.sv @@
`default_nettype none
module sgsc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire sgsc_pkg::sgsc_status_t status_i,
  output sgsc_pkg::sgsc_cmd_t        cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_GOAL   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q, state_d;

  // Sequence one beat through execute, lookup, optional apply and goal, and report
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (status_i.search_done) begin
          state_d = status_i.apply_en ? S_APPLY : S_OUT;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d = S_GOAL;
      end
      S_GOAL: begin
        cmd_o.goal = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sgsc_datapath.sv @@
`default_nettype none
module sgsc_datapath #(
  parameter int MAX_SERVOS = sgsc_pkg::MaxServosDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sgsc_pkg::sgsc_cmd_t cmd_i,
  output sgsc_pkg::sgsc_status_t  status_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic [3:0]         operation_i,
  input  wire logic               safety_pin_i,
  input  wire logic [7:0]         servo_id_i,
  input  wire logic               flag_value_i,
  input  wire logic signed [31:0] target_position_i,
  input  wire logic signed [31:0] requested_velocity_i,
  output logic [1:0]              event_res_o,
  output logic                    path_ready_o,
  output logic                    fault_active_o,
  output logic [1:0]              fault_cause_o,
  output logic                    safety_combined_o,
  output logic [15:0]             heartbeat_age_o,
  output logic [4:0]              known_count_o,
  output logic [31:0]             command_count_o,
  output logic [31:0]             reject_count_o,
  output logic signed [31:0]      present_position_o,
  output logic                    torque_state_o,
  output logic [14:0]             velocity_applied_o
);

  localparam int CNT_W = $clog2(MAX_SERVOS + 1);
  localparam int IDX_W = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

  // Configuration
  logic [15:0] hb_timeout_q, goal_step_q;
  logic [14:0] max_vel_q;
  logic [4:0]  scan_cnt_q;

  // Latched beat
  logic [3:0]         op_q;
  logic               pin_q, flag_q;
  logic [7:0]         sid_q;
  logic signed [31:0] tgt_q, vel_q;

  // Block state
  logic        hb_seen_q, hb_seen_d;
  logic [15:0] hb_timer_q, hb_timer_d;
  logic        host_ok_q, host_ok_d;
  logic        fault_q, fault_d;
  logic [1:0]  reason_q, reason_d;
  logic [7:0]  ids_q [MAX_SERVOS];
  logic [7:0]  ids_d [MAX_SERVOS];
  logic signed [31:0] pos_q [MAX_SERVOS];
  logic signed [31:0] pos_d [MAX_SERVOS];
  logic [MAX_SERVOS-1:0] torque_q, torque_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [31:0] cmds_q, cmds_d, rejs_q, rejs_d;

  // Per-beat working registers
  logic [1:0]         ev_q, ev_d;
  logic [14:0]        velapp_q, velapp_d;
  logic               apply_en_q, apply_en_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic signed [32:0] delta_q, delta_d;

  logic ready_now;
  logic match;
  logic signed [31:0] cur_pos;

  assign ready_now = (pin_q | host_ok_q) & hb_seen_q & (hb_timer_q < hb_timeout_q) & ~fault_q;
  assign match = (idx_q < count_q) && (ids_q[idx_q[IDX_W-1:0]] == sid_q);
  assign cur_pos = pos_q[slot_q];

  assign status_o.search_done = match || (idx_q >= count_q);
  assign status_o.apply_en = apply_en_q;

  always_comb begin
    logic [15:0] tmr;
    logic [CNT_W-1:0] scan_n;
    logic rej;
    logic signed [32:0] stp, goal;
    hb_seen_d  = hb_seen_q;
    hb_timer_d = hb_timer_q;
    host_ok_d  = host_ok_q;
    fault_d    = fault_q;
    reason_d   = reason_q;
    ids_d      = ids_q;
    pos_d      = pos_q;
    torque_d   = torque_q;
    count_d    = count_q;
    cmds_d     = cmds_q;
    rejs_d     = rejs_q;
    ev_d       = ev_q;
    velapp_d   = velapp_q;
    apply_en_d = apply_en_q;
    idx_d      = idx_q;
    found_d    = found_q;
    slot_d     = slot_q;
    delta_d    = delta_q;
    tmr        = hb_timer_q;
    scan_n     = (32'(scan_cnt_q) > 32'(MAX_SERVOS)) ? CNT_W'(MAX_SERVOS) : CNT_W'(scan_cnt_q);
    rej        = 1'b0;
    stp        = {17'b0, goal_step_q};
    goal       = {tgt_q[31], tgt_q};

    if (cmd_i.exec) begin
      // Count, gate, then run the operation
      ev_d = sgsc_pkg::EV_DONE;
      velapp_d = '0;
      apply_en_d = 1'b0;
      idx_d = '0;
      found_d = 1'b0;
      if (op_q != sgsc_pkg::OP_TICK) cmds_d = cmds_q + 32'd1;
      if (op_q >= sgsc_pkg::OP_ENABLE_ALL && op_q <= sgsc_pkg::OP_VELOCITY && !ready_now) begin
        rej = 1'b1;
        rejs_d = rejs_q + 32'd1;
        ev_d = sgsc_pkg::EV_REJECT;
      end
      if (!rej) begin
        case (op_q)
          sgsc_pkg::OP_TICK: begin
            if (hb_seen_q && hb_timer_q != sgsc_pkg::AGE_MAX) tmr = hb_timer_q + 16'd1;
            hb_timer_d = tmr;
            if (hb_seen_q && tmr >= hb_timeout_q && !fault_q) begin
              fault_d = 1'b1;
              reason_d = sgsc_pkg::CAUSE_HB;
              host_ok_d = 1'b0;
              torque_d = '0;
              ev_d = sgsc_pkg::EV_FAULT;
            end
            if (!pin_q && host_ok_d) begin
              fault_d = 1'b1;
              reason_d = sgsc_pkg::CAUSE_SAFETY;
              host_ok_d = 1'b0;
              torque_d = '0;
              ev_d = sgsc_pkg::EV_FAULT;
            end
          end
          sgsc_pkg::OP_HEARTBEAT: begin
            hb_seen_d = 1'b1;
            hb_timer_d = '0;
          end
          sgsc_pkg::OP_SAFETY: begin
            host_ok_d = flag_q;
            if (flag_q && pin_q) begin
              fault_d = 1'b0;
              reason_d = sgsc_pkg::CAUSE_NONE;
            end
            if (!flag_q) begin
              fault_d = 1'b1;
              reason_d = sgsc_pkg::CAUSE_SAFETY;
              host_ok_d = 1'b0;
              torque_d = '0;
              ev_d = sgsc_pkg::EV_FAULT;
            end
          end
          sgsc_pkg::OP_STOP: begin
            if (!ready_now) begin
              fault_d = 1'b1;
              reason_d = sgsc_pkg::CAUSE_SAFETY;
              host_ok_d = 1'b0;
              torque_d = '0;
              ev_d = sgsc_pkg::EV_FAULT;
            end
          end
          sgsc_pkg::OP_DISABLE: torque_d = '0;
          sgsc_pkg::OP_SCAN: begin
            count_d = scan_n;
            for (int i = 0; i < MAX_SERVOS; i++) begin
              if (CNT_W'(i) < scan_n) begin
                ids_d[i] = 8'(i + 1);
                pos_d[i] = sgsc_pkg::HOME_POSITION;
                torque_d[i] = 1'b0;
              end
            end
          end
          sgsc_pkg::OP_ENABLE_ALL: begin
            for (int i = 0; i < MAX_SERVOS; i++) begin
              if (CNT_W'(i) < count_q) torque_d[i] = flag_q;
            end
          end
          sgsc_pkg::OP_ENABLE_ONE, sgsc_pkg::OP_GOAL: apply_en_d = 1'b1;
          sgsc_pkg::OP_VELOCITY: begin
            if (vel_q[31]) velapp_d = '0;
            else if (vel_q > $signed({17'b0, max_vel_q})) velapp_d = max_vel_q;
            else velapp_d = vel_q[14:0];
          end
          sgsc_pkg::OP_CLEAR: begin
            if (pin_q) begin
              fault_d = 1'b0;
              reason_d = sgsc_pkg::CAUSE_NONE;
              host_ok_d = 1'b1;
              hb_seen_d = 1'b1;
              hb_timer_d = '0;
            end else begin
              ev_d = sgsc_pkg::EV_REFUSED;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd_i.search) begin
      // Walk the id table one entry a cycle
      if (match) begin
        found_d = 1'b1;
        slot_d = idx_q[IDX_W-1:0];
      end else if (idx_q < count_q) begin
        idx_d = idx_q + CNT_W'(1);
      end
    end else if (cmd_i.apply) begin
      // Append an unknown id while room remains, set torque for enable-one, take goal difference
      if (!found_q && count_q < CNT_W'(MAX_SERVOS)) begin
        slot_d = count_q[IDX_W-1:0];
        found_d = 1'b1;
        ids_d[count_q[IDX_W-1:0]] = sid_q;
        pos_d[count_q[IDX_W-1:0]] = sgsc_pkg::HOME_POSITION;
        torque_d[count_q[IDX_W-1:0]] = 1'b0;
        count_d = count_q + CNT_W'(1);
      end else if (found_q && op_q == sgsc_pkg::OP_ENABLE_ONE) begin
        torque_d[slot_q] = flag_q;
      end
      if (!found_q && count_q < CNT_W'(MAX_SERVOS) && op_q == sgsc_pkg::OP_ENABLE_ONE) begin
        torque_d[count_q[IDX_W-1:0]] = flag_q;
      end
      delta_d = {tgt_q[31], tgt_q} - {cur_pos[31], cur_pos};
    end else if (cmd_i.goal) begin
      // Clamp the goal and store it while torque is on
      if (delta_q > stp) goal = {cur_pos[31], cur_pos} + stp;
      else if (delta_q < -stp) goal = {cur_pos[31], cur_pos} - stp;
      if (op_q == sgsc_pkg::OP_GOAL && found_q && torque_q[slot_q]) begin
        pos_d[slot_q] = goal[31:0];
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_timeout_q <= sgsc_pkg::HB_TIMEOUT_RST;
      goal_step_q  <= sgsc_pkg::GOAL_STEP_RST;
      max_vel_q    <= sgsc_pkg::MAX_VEL_RST;
      scan_cnt_q   <= sgsc_pkg::SCAN_CNT_RST;
      hb_seen_q    <= 1'b0;
      hb_timer_q   <= '0;
      host_ok_q    <= 1'b0;
      fault_q      <= 1'b1;
      reason_q     <= sgsc_pkg::CAUSE_SAFETY;
      torque_q     <= '0;
      count_q      <= '0;
      cmds_q       <= '0;
      rejs_q       <= '0;
      apply_en_q   <= 1'b0;
      found_q      <= 1'b0;
      idx_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sgsc_pkg::REG_HB_TIMEOUT: hb_timeout_q <= cfg_data_i;
          sgsc_pkg::REG_GOAL_STEP:  goal_step_q  <= cfg_data_i;
          sgsc_pkg::REG_MAX_VEL:    max_vel_q    <= cfg_data_i[14:0];
          sgsc_pkg::REG_SCAN_CNT:   scan_cnt_q   <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      hb_seen_q  <= hb_seen_d;
      hb_timer_q <= hb_timer_d;
      host_ok_q  <= host_ok_d;
      fault_q    <= fault_d;
      reason_q   <= reason_d;
      torque_q   <= torque_d;
      count_q    <= count_d;
      cmds_q     <= cmds_d;
      rejs_q     <= rejs_d;
      apply_en_q <= apply_en_d;
      found_q    <= found_d;
      idx_q      <= idx_d;
    end
  end

  // Payload: beat fields, tables, working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      pin_q  <= safety_pin_i;
      sid_q  <= servo_id_i;
      flag_q <= flag_value_i;
      tgt_q  <= target_position_i;
      vel_q  <= requested_velocity_i;
    end
    ids_q    <= ids_d;
    pos_q    <= pos_d;
    ev_q     <= ev_d;
    velapp_q <= velapp_d;
    slot_q   <= slot_d;
    delta_q  <= delta_d;
  end

  assign event_res_o        = ev_q;
  assign path_ready_o       = ready_now;
  assign fault_active_o     = fault_q;
  assign fault_cause_o      = reason_q;
  assign safety_combined_o  = pin_q | host_ok_q;
  assign heartbeat_age_o    = hb_seen_q ? hb_timer_q : sgsc_pkg::AGE_MAX;
  assign known_count_o      = 5'(count_q);
  assign command_count_o    = cmds_q;
  assign reject_count_o     = rejs_q;
  assign present_position_o = found_q ? cur_pos : 32'sd0;
  assign torque_state_o     = found_q & torque_q[slot_q];
  assign velocity_applied_o = velapp_q;

endmodule
`default_nettype wire

@@ rtl/safety_gated_servo_command_gate.sv @@
// An input beat is latched, executed and looked up in the id table; accepted
// enable-one and goal beats then update the table before the result beat.
// One beat at a time: a new beat is taken only once the result beat of the
// last one is accepted; the id table walk is sequential.
// Reset (rst_ni low, asynchronous): fault latched with safety cause,
// counters, heartbeat, torque flags and id count cleared, registers at defaults.
`default_nettype none
module safety_gated_servo_command_gate #(
  parameter int MAX_SERVOS = sgsc_pkg::MaxServosDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         operation_i,
  input  wire logic               safety_pin_i,
  input  wire logic [7:0]         servo_id_i,
  input  wire logic               flag_value_i,
  input  wire logic signed [31:0] target_position_i,
  input  wire logic signed [31:0] requested_velocity_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              event_res_o,
  output logic                    path_ready_o,
  output logic                    fault_active_o,
  output logic [1:0]              fault_cause_o,
  output logic                    safety_combined_o,
  output logic [15:0]             heartbeat_age_o,
  output logic [4:0]              known_count_o,
  output logic [31:0]             command_count_o,
  output logic [31:0]             reject_count_o,
  output logic signed [31:0]      present_position_o,
  output logic                    torque_state_o,
  output logic [14:0]             velocity_applied_o
);

  sgsc_pkg::sgsc_cmd_t    cmd;
  sgsc_pkg::sgsc_status_t status;

  assign cfg_ready_o = 1'b1;

  sgsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sgsc_datapath #(
    .MAX_SERVOS (MAX_SERVOS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (operation_i),
    .safety_pin_i         (safety_pin_i),
    .servo_id_i           (servo_id_i),
    .flag_value_i         (flag_value_i),
    .target_position_i    (target_position_i),
    .requested_velocity_i (requested_velocity_i),
    .event_res_o          (event_res_o),
    .path_ready_o         (path_ready_o),
    .fault_active_o       (fault_active_o),
    .fault_cause_o        (fault_cause_o),
    .safety_combined_o    (safety_combined_o),
    .heartbeat_age_o      (heartbeat_age_o),
    .known_count_o        (known_count_o),
    .command_count_o      (command_count_o),
    .reject_count_o       (reject_count_o),
    .present_position_o   (present_position_o),
    .torque_state_o       (torque_state_o),
    .velocity_applied_o   (velocity_applied_o)
  );

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int NumServos = 16;
  localparam int RandomItems = 950;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [3:0]         operation;
    logic               safety_pin;
    logic [7:0]         servo_id;
    logic               flag_value;
    logic signed [31:0] target_position;
    logic signed [31:0] requested_velocity;
  } gate_cmd_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic               path_ready;
    logic               fault_active;
    logic [1:0]         fault_cause;
    logic               safety_combined;
    logic [15:0]        heartbeat_age;
    logic [4:0]         known_count;
    logic [31:0]        command_count;
    logic [31:0]        reject_count;
    logic signed [31:0] present_position;
    logic               torque_state;
    logic [14:0]        velocity_applied;
  } gate_resp_t;

  // Scoreboard: shadow of the gate state and the queue of expected responses
  class gate_scoreboard;
    logic [15:0] hb_timeout;
    logic [15:0] goal_step;
    logic [14:0] vel_max;
    logic [4:0]  scan_cnt;
    logic        hb_seen;
    logic [15:0] hb_timer;
    logic        host_ok;
    logic        latched;
    logic [1:0]  cause;
    logic [7:0]  ids [NumServos];
    logic signed [31:0] pos [NumServos];
    logic        torque [NumServos];
    int          id_cnt;
    logic [31:0] cmd_cnt;
    logic [31:0] rej_cnt;
    gate_resp_t  pending [$];
    int          errors;

    function new();
      hb_timeout = sgsc_pkg::HB_TIMEOUT_RST;
      goal_step = sgsc_pkg::GOAL_STEP_RST;
      vel_max = sgsc_pkg::MAX_VEL_RST;
      scan_cnt = sgsc_pkg::SCAN_CNT_RST;
      hb_seen = 0;
      hb_timer = 0;
      host_ok = 0;
      latched = 1;
      cause = sgsc_pkg::CAUSE_SAFETY;
      id_cnt = 0;
      cmd_cnt = 0;
      rej_cnt = 0;
      errors = 0;
      for (int i = 0; i < NumServos; i++) begin
        ids[i] = 0;
        pos[i] = 0;
        torque[i] = 0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        sgsc_pkg::REG_HB_TIMEOUT: hb_timeout = data;
        sgsc_pkg::REG_GOAL_STEP:  goal_step = data;
        sgsc_pkg::REG_MAX_VEL:    vel_max = data[14:0];
        default:                  scan_cnt = data[4:0];
      endcase
    endfunction

    function void trip(logic [1:0] why);
      latched = 1;
      cause = why;
      host_ok = 0;
      for (int i = 0; i < NumServos; i++) torque[i] = 0;
    endfunction

    function bit ready(logic pin);
      return (pin || host_ok) && hb_seen && (hb_timer < hb_timeout) && !latched;
    endfunction

    function int slot_of(logic [7:0] id);
      for (int i = 0; i < id_cnt; i++) if (ids[i] == id) return i;
      return -1;
    endfunction

    function int add_id(logic [7:0] id);
      int s;
      s = slot_of(id);
      if (s >= 0) return s;
      if (id_cnt >= NumServos) return -1;
      ids[id_cnt] = id;
      pos[id_cnt] = sgsc_pkg::HOME_POSITION;
      torque[id_cnt] = 0;
      id_cnt++;
      return id_cnt - 1;
    endfunction

    // Note an accepted command beat and queue its expected response
    function void note_cmd(gate_cmd_t c);
      gate_resp_t r;
      int s;
      longint cur, goal, delta, stp, v;
      r = '0;
      if (c.operation != sgsc_pkg::OP_TICK) cmd_cnt++;
      if (c.operation >= sgsc_pkg::OP_ENABLE_ALL && c.operation <= sgsc_pkg::OP_VELOCITY &&
          !ready(c.safety_pin)) begin
        rej_cnt++;
        r.event_res = sgsc_pkg::EV_REJECT;
      end else begin
        case (c.operation)
          sgsc_pkg::OP_TICK: begin
            if (hb_seen && hb_timer != sgsc_pkg::AGE_MAX) hb_timer++;
            if (hb_seen && hb_timer >= hb_timeout && !latched) begin
              trip(sgsc_pkg::CAUSE_HB);
              r.event_res = sgsc_pkg::EV_FAULT;
            end
            if (!c.safety_pin && host_ok) begin
              trip(sgsc_pkg::CAUSE_SAFETY);
              r.event_res = sgsc_pkg::EV_FAULT;
            end
          end
          sgsc_pkg::OP_HEARTBEAT: begin
            hb_seen = 1;
            hb_timer = 0;
          end
          sgsc_pkg::OP_SAFETY: begin
            host_ok = c.flag_value;
            if (c.flag_value && c.safety_pin) begin
              latched = 0;
              cause = sgsc_pkg::CAUSE_NONE;
            end
            if (!c.flag_value) begin
              trip(sgsc_pkg::CAUSE_SAFETY);
              r.event_res = sgsc_pkg::EV_FAULT;
            end
          end
          sgsc_pkg::OP_STOP: begin
            if (!ready(c.safety_pin)) begin
              trip(sgsc_pkg::CAUSE_SAFETY);
              r.event_res = sgsc_pkg::EV_FAULT;
            end
          end
          sgsc_pkg::OP_DISABLE: for (int i = 0; i < NumServos; i++) torque[i] = 0;
          sgsc_pkg::OP_SCAN: begin
            id_cnt = 0;
            for (int i = 0; i < scan_cnt && i < NumServos; i++) begin
              ids[i] = 8'(i + 1);
              pos[i] = sgsc_pkg::HOME_POSITION;
              torque[i] = 0;
              id_cnt++;
            end
          end
          sgsc_pkg::OP_ENABLE_ALL: for (int i = 0; i < id_cnt; i++) torque[i] = c.flag_value;
          sgsc_pkg::OP_ENABLE_ONE: begin
            s = add_id(c.servo_id);
            if (s >= 0) torque[s] = c.flag_value;
          end
          sgsc_pkg::OP_GOAL: begin
            s = add_id(c.servo_id);
            if (s >= 0) begin
              cur = pos[s];
              goal = c.target_position;
              stp = goal_step;
              delta = goal - cur;
              if (delta > stp) goal = cur + stp;
              if (delta < -stp) goal = cur - stp;
              if (torque[s]) pos[s] = goal[31:0];
            end
          end
          sgsc_pkg::OP_VELOCITY: begin
            v = c.requested_velocity;
            if (v > longint'(vel_max)) v = vel_max;
            if (v < 0) v = 0;
            r.velocity_applied = v[14:0];
          end
          sgsc_pkg::OP_CLEAR: begin
            if (c.safety_pin) begin
              latched = 0;
              cause = sgsc_pkg::CAUSE_NONE;
              host_ok = 1;
              hb_seen = 1;
              hb_timer = 0;
            end else begin
              r.event_res = sgsc_pkg::EV_REFUSED;
            end
          end
          default: ;
        endcase
      end
      s = slot_of(c.servo_id);
      r.path_ready = ready(c.safety_pin);
      r.fault_active = latched;
      r.fault_cause = cause;
      r.safety_combined = c.safety_pin || host_ok;
      r.heartbeat_age = hb_seen ? hb_timer : sgsc_pkg::AGE_MAX;
      r.known_count = 5'(id_cnt);
      r.command_count = cmd_cnt;
      r.reject_count = rej_cnt;
      r.present_position = (s >= 0) ? pos[s] : 32'sd0;
      r.torque_state = (s >= 0) ? torque[s] : 1'b0;
      pending.push_back(r);
    endfunction

    function void field(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    // Compare a response beat with the oldest expectation
    function void check_resp(gate_resp_t a);
      gate_resp_t e;
      if (pending.size() == 0) begin
        $error("response beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      field("event_res", e.event_res, a.event_res);
      field("path_ready", e.path_ready, a.path_ready);
      field("fault_active", e.fault_active, a.fault_active);
      field("fault_cause", e.fault_cause, a.fault_cause);
      field("safety_combined", e.safety_combined, a.safety_combined);
      field("heartbeat_age", e.heartbeat_age, a.heartbeat_age);
      field("known_count", e.known_count, a.known_count);
      field("command_count", e.command_count, a.command_count);
      field("reject_count", e.reject_count, a.reject_count);
      field("present_position", e.present_position, a.present_position);
      field("torque_state", e.torque_state, a.torque_state);
      field("velocity_applied", e.velocity_applied, a.velocity_applied);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  gate_cmd_t cmd_q = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  gate_resp_t resp;
  gate_scoreboard board;
  bit idle_on = 1;
  longint cycles = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  safety_gated_servo_command_gate uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .operation_i(cmd_q.operation), .safety_pin_i(cmd_q.safety_pin),
    .servo_id_i(cmd_q.servo_id), .flag_value_i(cmd_q.flag_value),
    .target_position_i(cmd_q.target_position),
    .requested_velocity_i(cmd_q.requested_velocity),
    .out_valid_o, .out_ready_i,
    .event_res_o(resp.event_res), .path_ready_o(resp.path_ready),
    .fault_active_o(resp.fault_active), .fault_cause_o(resp.fault_cause),
    .safety_combined_o(resp.safety_combined), .heartbeat_age_o(resp.heartbeat_age),
    .known_count_o(resp.known_count), .command_count_o(resp.command_count),
    .reject_count_o(resp.reject_count), .present_position_o(resp.present_position),
    .torque_state_o(resp.torque_state), .velocity_applied_o(resp.velocity_applied)
  );

  // Watchdog on total run length
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Check response beats at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_resp(resp);
  end

  // Stall the response side in random bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        n = $urandom_range(1, 15);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic drive_cmd(gate_cmd_t c);
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 15);
      repeat (n) @(negedge clk_i);
    end
    cmd_q <= c;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_cmd(c);
    @(negedge clk_i);
    in_valid_i <= 0;
    // Let the drop of valid land before the next beat is offered
    @(negedge clk_i);
  endtask

  // Wait for all responses, then let the block settle before a register write
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  function automatic gate_cmd_t mk(logic [3:0] op, logic pin, logic [7:0] id, logic flag,
                                   logic [31:0] tgt, logic [31:0] vel);
    gate_cmd_t c;
    c.operation = op;
    c.safety_pin = pin;
    c.servo_id = id;
    c.flag_value = flag;
    c.target_position = tgt;
    c.requested_velocity = vel;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_fffc + $urandom_range(0, 3);
      2: return 2048 + $urandom_range(0, 2000) - 1000;
      3: return $urandom_range(0, 40000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  // Random command beat with weighted operations, mostly with the safety pin high
  function automatic gate_cmd_t rand_cmd();
    logic [3:0] op;
    int r;
    logic [7:0] id;
    r = $urandom_range(0, 99);
    if (r < 18) op = sgsc_pkg::OP_TICK;
    else if (r < 28) op = sgsc_pkg::OP_HEARTBEAT;
    else if (r < 32) op = sgsc_pkg::OP_SAFETY;
    else if (r < 34) op = sgsc_pkg::OP_STOP;
    else if (r < 36) op = sgsc_pkg::OP_DISABLE;
    else if (r < 39) op = sgsc_pkg::OP_SCAN;
    else if (r < 45) op = sgsc_pkg::OP_ENABLE_ALL;
    else if (r < 57) op = sgsc_pkg::OP_ENABLE_ONE;
    else if (r < 77) op = sgsc_pkg::OP_GOAL;
    else if (r < 87) op = sgsc_pkg::OP_VELOCITY;
    else if (r < 95) op = sgsc_pkg::OP_CLEAR;
    else op = 4'($urandom_range(11, 15));
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
    return mk(op, $urandom_range(0, 9) != 0, id, $urandom_range(0, 3) != 0,
              rand_word(), rand_word());
  endfunction

  initial begin
    board = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: extremes, every operation but enable-all, refusals and overflow cases
    write_cfg(sgsc_pkg::REG_HB_TIMEOUT, 16'd3);
    drive_cmd(mk(sgsc_pkg::OP_ENABLE_ONE, 1, 8'd5, 1, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_CLEAR, 0, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_CLEAR, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_ENABLE_ONE, 1, 8'd255, 1, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_GOAL, 1, 8'd255, 0, 32'h7fff_ffff, 0));
    drive_cmd(mk(sgsc_pkg::OP_GOAL, 1, 8'd255, 0, 32'h8000_0000, 0));
    drive_cmd(mk(sgsc_pkg::OP_GOAL, 1, 8'd255, 0, 32'd2100, 0));
    drive_cmd(mk(sgsc_pkg::OP_VELOCITY, 1, 8'd255, 1, 32'h8000_0000, 32'h8000_0000));
    drive_cmd(mk(sgsc_pkg::OP_VELOCITY, 1, 8'd0, 1, 0, 32'h7fff_ffff));
    drive_cmd(mk(sgsc_pkg::OP_TICK, 1, 8'd255, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_TICK, 1, 8'd255, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_TICK, 1, 8'd255, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_STOP, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_SAFETY, 1, 8'd0, 1, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_HEARTBEAT, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_SAFETY, 0, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_CLEAR, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_TICK, 0, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_DISABLE, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(4'd15, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_SCAN, 1, 8'd0, 0, 0, 0));
    drain();
    write_cfg(sgsc_pkg::REG_SCAN_CNT, 16'd31);
    write_cfg(sgsc_pkg::REG_HB_TIMEOUT, 16'd0);
    write_cfg(sgsc_pkg::REG_GOAL_STEP, 16'd0);
    write_cfg(sgsc_pkg::REG_MAX_VEL, 16'h7fff);
    drive_cmd(mk(sgsc_pkg::OP_SCAN, 1, 8'd0, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_CLEAR, 1, 8'd3, 0, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_ENABLE_ONE, 1, 8'd200, 1, 0, 0));
    drive_cmd(mk(sgsc_pkg::OP_GOAL, 1, 8'd200, 0, 32'd9, 0));

    // Random phases with a fresh register setting each
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_cfg(sgsc_pkg::REG_HB_TIMEOUT, ph == 0 ? 16'hffff : 16'($urandom_range(1, 40)));
      write_cfg(sgsc_pkg::REG_GOAL_STEP, ph == 1 ? 16'hffff : 16'($urandom_range(0, 1500)));
      write_cfg(sgsc_pkg::REG_MAX_VEL, ph == 2 ? 16'd0 : 16'($urandom_range(0, 32767)));
      write_cfg(sgsc_pkg::REG_SCAN_CNT, 16'($urandom_range(0, 20)));
      if (ph == 7) idle_on = 0;
      drive_cmd(mk(sgsc_pkg::OP_CLEAR, 1, 8'd1, 1, 0, 0));
      for (int k = 0; k < RandomItems / 8; k++) drive_cmd(rand_cmd());
    end

    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sgsc_pkg.sv
rtl/sgsc_ctrl.sv
rtl/sgsc_datapath.sv
rtl/safety_gated_servo_command_gate.sv
test/tb_top.sv
